// File: hw/rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg - shared types and tables for the pattern step sequencer
// Item and result layouts, opcodes, traversal orders and the note scale.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int NUM_VOICES = 3;
    localparam int NUM_STEPS  = 16;

    localparam logic [9:0] TEMPO_RESET = 10'd150;
    localparam logic [3:0] SLOT_RESET  = 4'd15;

    typedef enum logic [1:0] {
        OP_TIME  = 2'd0,
        OP_WRITE = 2'd1,
        OP_MODE  = 2'd2
    } pss_op_t;

    typedef struct packed {
        pss_op_t     op;
        logic [31:0] now_ms;
        logic [3:0]  slot_index;
        logic [3:0]  slot_value;
        logic [1:0]  mode_select;
    } pss_item_t;

    typedef struct packed {
        logic       stepped;
        logic [3:0] played_slot;
        logic       note_on;
        logic [6:0] note_number;
        logic [3:0] voice;
        logic       pan_negative;
    } pss_result_t;

    localparam logic [6:0] NOTE_TABLE [16] = '{
        7'd36, 7'd40, 7'd43, 7'd45, 7'd55, 7'd52, 7'd48, 7'd60,
        7'd52, 7'd55, 7'd45, 7'd48, 7'd36, 7'd43, 7'd31, 7'd33
    };

    localparam logic [3:0] ORDER_TABLE [4][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
          4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd7, 4'd6, 4'd5, 4'd4,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd15, 4'd14, 4'd13, 4'd12},
        '{4'd0, 4'd1, 4'd4, 4'd8, 4'd5, 4'd2, 4'd3, 4'd6,
          4'd9, 4'd12, 4'd13, 4'd10, 4'd7, 4'd11, 4'd14, 4'd15}
    };

endpackage

// File: hw/rtl/pss_core.sv
// ----------------------------------------------------------------------------
// pss_core - sequencer state and step logic
// Holds the step slots, modes, position, step time, voice counter and tempo,
// and turns one registered item into one result combinationally.
// ----------------------------------------------------------------------------
module pss_core
    import pss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_data,
    input  logic        fire,
    input  pss_item_t   item,
    output pss_result_t result
);

    logic [9:0]  tempo_reg;
    logic [3:0]  slot_reg [16];
    logic [1:0]  play_mode_reg, play_mode_next;
    logic [1:0]  pending_mode_reg, pending_mode_next;
    logic [3:0]  position_reg, position_next;
    logic [31:0] last_time_reg, last_time_next;
    logic [3:0]  voice_reg, voice_next;

    logic        slot_we;
    logic [31:0] elapsed;
    logic        due;
    logic [3:0]  slot_sel;
    logic [3:0]  step_val;
    logic [4:0]  pos_inc;
    logic [4:0]  voice_inc;

    assign elapsed   = item.now_ms - last_time_reg;
    assign due       = (elapsed >= {22'd0, tempo_reg});
    assign slot_sel  = ORDER_TABLE[play_mode_reg][position_reg];
    assign step_val  = slot_reg[slot_sel];
    assign pos_inc   = {1'b0, position_reg} + 5'd1;
    assign voice_inc = {1'b0, voice_reg} + 5'd1;

    always_comb
    begin
        slot_we           = 1'b0;
        play_mode_next    = play_mode_reg;
        pending_mode_next = pending_mode_reg;
        position_next     = position_reg;
        last_time_next    = last_time_reg;
        voice_next        = voice_reg;
        result            = '0;
        if (fire)
        begin
            unique case (item.op)
                OP_WRITE: slot_we = 1'b1;
                OP_MODE:  pending_mode_next = item.mode_select;
                OP_TIME:
                begin
                    if (due)
                    begin
                        last_time_next     = item.now_ms;
                        result.stepped     = 1'b1;
                        result.played_slot = slot_sel;
                        // wrap the pattern and pick up the pending mode
                        if (pos_inc >= 5'(NUM_STEPS))
                        begin
                            position_next  = '0;
                            play_mode_next = pending_mode_reg;
                        end
                        else
                        begin
                            position_next = pos_inc[3:0];
                        end
                        if (step_val != 4'd0)
                        begin
                            result.note_on      = 1'b1;
                            result.note_number  = NOTE_TABLE[step_val];
                            result.voice        = voice_reg;
                            result.pan_negative = voice_reg[0];
                            voice_next = (voice_inc >= 5'(NUM_VOICES)) ? '0 : voice_inc[3:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_reg        <= TEMPO_RESET;
            play_mode_reg    <= '0;
            pending_mode_reg <= '0;
            position_reg     <= '0;
            last_time_reg    <= '0;
            voice_reg        <= '0;
            for (int i = 0; i < 16; i++)
            begin
                slot_reg[i] <= SLOT_RESET;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                tempo_reg <= cfg_data;
            end
            play_mode_reg    <= play_mode_next;
            pending_mode_reg <= pending_mode_next;
            position_reg     <= position_next;
            last_time_reg    <= last_time_next;
            voice_reg        <= voice_next;
            if (slot_we)
            begin
                slot_reg[item.slot_index] <= item.slot_value;
            end
        end
    end

endmodule

// File: hw/rtl/pattern_step_sequencer.sv
// ----------------------------------------------------------------------------
// pattern_step_sequencer - 16-step note sequencer
// Input register, combinational step logic, output register; one item a cycle while out_ready keeps up.
// ----------------------------------------------------------------------------
// Every item gives exactly one result. An item is taken into an input
// register, processed once the output register is free or draining and held
// in an output register until taken, so a new item is accepted every
// cycle while the output side keeps up; the combinational step logic between
// the two registers sets that rate. Write tempo_ms through cfg_we/cfg_data
// only while no item is in flight.
module pattern_step_sequencer
    import pss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [31:0] now_ms,
    input  logic [3:0]  slot_index,
    input  logic [3:0]  slot_value,
    input  logic [1:0]  mode_select,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        stepped,
    output logic [3:0]  played_slot,
    output logic        note_on,
    output logic [6:0]  note_number,
    output logic [3:0]  voice,
    output logic        pan_negative
);

    logic        in_valid_reg;
    pss_item_t   item_reg;
    logic        out_valid_reg;
    pss_result_t result_reg;
    pss_result_t result_next;
    logic        fire;

    // process the held item once the output register is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    pss_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .fire     (fire),
        .item     (item_reg),
        .result   (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{op:          pss_op_t'(op),
                          now_ms:      now_ms,
                          slot_index:  slot_index,
                          slot_value:  slot_value,
                          mode_select: mode_select};
        end
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign stepped      = result_reg.stepped;
    assign played_slot  = result_reg.played_slot;
    assign note_on      = result_reg.note_on;
    assign note_number  = result_reg.note_number;
    assign voice        = result_reg.voice;
    assign pan_negative = result_reg.pan_negative;

`ifndef SYNTHESIS
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg)
        else $error("held item dropped before processing");

    a_nonstep_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (item_reg.op != OP_TIME) |=> out_valid && !stepped && !note_on)
        else $error("non-time item produced a step");

    a_voice_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && note_on |-> stepped && ({1'b0, voice} < 5'(NUM_VOICES)))
        else $error("note result with bad voice or no step");
`endif

endmodule
